// ===== hdl/mos_pkg.sv =====
// Package for the median-of-set block: sizes, sequencer states and the
// command word that drives the cell chain. No dependencies.
`default_nettype none

package mos_pkg;

	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int RES_W    = DATA_W + 1;
	localparam int SIZE_W   = 7;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef logic signed [DATA_W-1:0] sample_t;
	typedef logic signed [RES_W-1:0]  result_t;
	typedef logic [CNT_W-1:0]         count_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_EMIT
	} state_t;

	// one command per cycle; at most one bit is set
	typedef struct packed {
		logic insert;
		logic shift;
		logic clear;
	} chain_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/mos_in_if.sv =====
// Input channel: one sample and its end-of-set flag per request.
// Depends on mos_pkg.
`default_nettype none

interface mos_in_if;
	logic            valid;
	logic            ready;
	mos_pkg::sample_t sample;
	logic            last;

	modport source (output valid, output sample, output last, input ready);
	modport sink   (input valid, input sample, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/mos_out_if.sv =====
// Output channel: median (Q16.17), set size and overflow flag per request.
// Depends on mos_pkg.
`default_nettype none

interface mos_out_if;
	logic                        valid;
	logic                        ready;
	mos_pkg::result_t            median_doubled;
	logic [mos_pkg::SIZE_W-1:0]  set_size;
	logic                        overflowed;

	modport source (output valid, output median_doubled, output set_size,
		output overflowed, input ready);
	modport sink   (input valid, input median_doubled, input set_size,
		input overflowed, output ready);
endinterface

`default_nettype wire

// ===== hdl/median_of_set_core.sv =====
// Median of a set of Q16.16 samples by sorted insertion into a cell chain.
// Throughput: one sample per cycle while a set is being collected.
// On the last sample the chain shifts down floor((n-1)/2) places, one per cycle,
// then the median is registered once the output register is free; input ready
// is low until then.
// Reset clears sequencer, counts, cell occupied bits, output valid; not cell data.
`default_nettype none

module median_of_set_core (
	input  wire logic clk,
	input  wire logic arst_n,
	mos_in_if.sink    in_ch,
	mos_out_if.source out_ch
);

	mos_pkg::state_t     state_q, state_nxt;
	mos_pkg::count_t     count_q, count_nxt;
	mos_pkg::count_t     shift_q, shift_nxt;
	logic                dropped_q, dropped_nxt;
	mos_pkg::chain_cmd_t cmd;
	mos_pkg::sample_t    head0, head1;
	logic                full;
	logic                accept;
	logic                load;
	mos_pkg::count_t     n_new;
	mos_pkg::count_t     n_dec;
	mos_pkg::result_t    median;

	logic                         out_valid_q;
	mos_pkg::result_t             median_q;
	logic [mos_pkg::SIZE_W-1:0]   size_q;
	logic                         ovf_q;

	mos_chain u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.new_val (in_ch.sample),
		.head0   (head0),
		.head1   (head1),
		.full    (full)
	);

	assign in_ch.ready = (state_q == mos_pkg::ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign n_new       = count_q + mos_pkg::count_t'(!full);
	assign n_dec       = n_new - mos_pkg::count_t'(1);

	// odd count: twice the middle value; even: sum of the two middle values
	always_comb begin
		if (count_q[0]) begin
			median = {head0, 1'b0};
		end else begin
			median = mos_pkg::result_t'(head0) + mos_pkg::result_t'(head1);
		end
	end

	always_comb begin
		state_nxt   = state_q;
		count_nxt   = count_q;
		shift_nxt   = shift_q;
		dropped_nxt = dropped_q;
		cmd         = '0;
		load        = 1'b0;
		unique case (state_q)
			mos_pkg::ST_IDLE: begin
				if (accept) begin
					cmd.insert  = !full;
					count_nxt   = n_new;
					dropped_nxt = dropped_q | full;
					if (in_ch.last) begin
						shift_nxt = n_dec >> 1;
						state_nxt = mos_pkg::ST_SHIFT;
					end
				end
			end
			mos_pkg::ST_SHIFT: begin
				if (shift_q == '0) begin
					state_nxt = mos_pkg::ST_EMIT;
				end else begin
					cmd.shift = 1'b1;
					shift_nxt = shift_q - mos_pkg::count_t'(1);
				end
			end
			mos_pkg::ST_EMIT: begin
				if (!out_valid_q || out_ch.ready) begin
					load        = 1'b1;
					cmd.clear   = 1'b1;
					count_nxt   = '0;
					dropped_nxt = 1'b0;
					state_nxt   = mos_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = mos_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mos_pkg::ST_IDLE;
			count_q     <= '0;
			shift_q     <= '0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_nxt;
			count_q   <= count_nxt;
			shift_q   <= shift_nxt;
			dropped_q <= dropped_nxt;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			median_q <= median;
			size_q   <= count_q[mos_pkg::SIZE_W-1:0];
			ovf_q    <= dropped_q;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.median_doubled = median_q;
	assign out_ch.set_size       = size_q;
	assign out_ch.overflowed     = ovf_q;

endmodule

`default_nettype wire

// ===== hdl/mos_cell.sv =====
// One cell of the sorting chain: holds a value and its occupied bit.
// Depends on mos_pkg.
`default_nettype none

module mos_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mos_pkg::chain_cmd_t cmd,
	input  wire mos_pkg::sample_t    new_val,
	input  wire logic                prev_valid,
	input  wire logic                prev_greater,
	input  wire mos_pkg::sample_t    prev_val,
	input  wire mos_pkg::sample_t    next_val,
	output mos_pkg::sample_t         val,
	output logic                     valid,
	output logic                     greater
);

	mos_pkg::sample_t val_q;
	logic             valid_q;

	assign greater = valid_q && (val_q > new_val);
	assign val     = val_q;
	assign valid   = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clear) begin
			valid_q <= 1'b0;
		end else if (cmd.insert) begin
			valid_q <= valid_q | prev_valid;
		end
	end

	// equal values stay ahead of the new one: strict compare
	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			if (prev_greater) begin
				val_q <= prev_val;
			end else if (greater || (!valid_q && prev_valid)) begin
				val_q <= new_val;
			end
		end else if (cmd.shift) begin
			val_q <= next_val;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/mos_chain.sv =====
// Row of sorting cells, ascending from cell 0. Insert ripples larger values
// up one place; shift moves every value down one place. Depends on mos_pkg, mos_cell.
`default_nettype none

module mos_chain (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mos_pkg::chain_cmd_t cmd,
	input  wire mos_pkg::sample_t    new_val,
	output mos_pkg::sample_t         head0,
	output mos_pkg::sample_t         head1,
	output logic                     full
);

	localparam int N = mos_pkg::CAPACITY;

	mos_pkg::sample_t val     [N];
	logic             valid   [N];
	logic             greater [N];

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic             pv;
		logic             pg;
		mos_pkg::sample_t pval;
		mos_pkg::sample_t nval;

		if (i == 0) begin : g_first
			assign pv   = 1'b1;
			assign pg   = 1'b0;
			assign pval = new_val;
		end else begin : g_mid
			assign pv   = valid[i-1];
			assign pg   = greater[i-1];
			assign pval = val[i-1];
		end

		if (i == N - 1) begin : g_last
			assign nval = val[i];
		end else begin : g_inner
			assign nval = val[i+1];
		end

		mos_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cmd          (cmd),
			.new_val      (new_val),
			.prev_valid   (pv),
			.prev_greater (pg),
			.prev_val     (pval),
			.next_val     (nval),
			.val          (val[i]),
			.valid        (valid[i]),
			.greater      (greater[i])
		);
	end

	assign head0 = val[0];
	assign full  = valid[N-1];

	if (N > 1) begin : g_h1
		assign head1 = val[1];
	end else begin : g_h1_single
		assign head1 = val[0];
	end

endmodule

`default_nettype wire

// ===== tb/median_of_set_checker.sv =====
// Checker for median_of_set_core: watches both channels, keeps its own sorted
// copy of the current set and compares every median against it.
// Depends on mos_pkg, mos_in_if and mos_out_if.
`default_nettype none

module median_of_set_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	mos_in_if         in_ch,
	mos_out_if        out_ch,
	input  wire logic done,
	output int        errors,
	output int        medians_checked,
	output int        outstanding
);

	typedef struct packed {
		mos_pkg::result_t            median_doubled;
		logic [mos_pkg::SIZE_W-1:0]  set_size;
		logic                        overflowed;
	} median_t;

	mos_pkg::sample_t chain [mos_pkg::CAPACITY];
	int      chain_n       = 0;
	logic    chain_dropped = 1'b0;
	median_t expected_medians[$];
	logic    done_seen     = 1'b0;
	int      error_cnt     = 0;
	int      checked_cnt   = 0;
	int      pending_cnt   = 0;

	assign errors          = error_cnt;
	assign medians_checked = checked_cnt;
	assign outstanding     = pending_cnt;

	task automatic report(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		error_cnt++;
	endtask

	function automatic median_t take_median();
		median_t          m;
		int               mid;
		mos_pkg::result_t lo;
		mos_pkg::result_t hi;
		mid = chain_n / 2;
		hi  = chain[mid];
		// even count: the two middle cells; odd count: the middle one twice
		lo  = (chain_n % 2 == 0) ? chain[mid-1] : chain[mid];
		m.median_doubled = lo + hi;
		m.set_size       = chain_n[mos_pkg::SIZE_W-1:0];
		m.overflowed     = chain_dropped;
		return m;
	endfunction

	task automatic absorb_sample(input mos_pkg::sample_t s, input logic is_last);
		int pos;
		if (chain_n < mos_pkg::CAPACITY) begin
			pos = chain_n;
			// new value goes after any equal ones already held
			while (pos > 0 && chain[pos-1] > s) begin
				chain[pos] = chain[pos-1];
				pos--;
			end
			chain[pos] = s;
			chain_n++;
		end else begin
			chain_dropped = 1'b1;
		end
		if (is_last) begin
			expected_medians.push_back(take_median());
			chain_n       = 0;
			chain_dropped = 1'b0;
		end
	endtask

	task automatic check_median();
		median_t want;
		if (expected_medians.size() == 0) begin
			report($sformatf("unexpected result median_doubled=%0d set_size=%0d",
				out_ch.median_doubled, out_ch.set_size));
		end else begin
			want = expected_medians.pop_front();
			checked_cnt++;
			if (out_ch.median_doubled !== want.median_doubled)
				report($sformatf("median_doubled got %0d expected %0d (set of %0d)",
					out_ch.median_doubled, want.median_doubled, want.set_size));
			if (out_ch.set_size !== want.set_size)
				report($sformatf("set_size got %0d expected %0d",
					out_ch.set_size, want.set_size));
			if (out_ch.overflowed !== want.overflowed)
				report($sformatf("overflowed got %0b expected %0b (set of %0d)",
					out_ch.overflowed, want.overflowed, want.set_size));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_n       = 0;
			chain_dropped = 1'b0;
			expected_medians.delete();
			pending_cnt   = 0;
		end else begin
			if (out_ch.valid && out_ch.ready)
				check_median();
			if (in_ch.valid && in_ch.ready)
				absorb_sample(in_ch.sample, in_ch.last);
			if (done && !done_seen) begin
				done_seen = 1'b1;
				if (expected_medians.size() != 0)
					report($sformatf("%0d expected medians never arrived",
						expected_medians.size()));
			end
			pending_cnt = expected_medians.size();
		end
	end

endmodule

`default_nettype wire

// ===== tb/median_of_set_core_tb.sv =====
// Top of the median_of_set_core testbench: clock, reset, sample sets and
// flow control; the checker beside the block does the comparing.
// Depends on mos_pkg, mos_in_if, mos_out_if and median_of_set_checker.
`default_nettype none

module median_of_set_core_tb;

	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_BUDGET = 210;

	logic clk = 1'b0;
	logic arst_n;
	logic rx_hold = 1'b0;
	logic done;
	int   tx_idle = 0;
	int   rx_idle = 0;
	int   phase = 0;
	int   errors;
	int   medians_checked;
	int   outstanding;
	int   sets_sent = 0;
	int   samples_stored = 0;
	int   full_sets = 0;

	mos_in_if  in_ch();
	mos_out_if out_ch();

	median_of_set_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	median_of_set_checker median_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_ch           (in_ch),
		.out_ch          (out_ch),
		.done            (done),
		.errors          (errors),
		.medians_checked (medians_checked),
		.outstanding     (outstanding)
	);

	always #2 clk = ~clk;

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	always @(posedge clk) begin
		out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle);
	end

	// long output stall once the sender runs flat out, so the block backs up
	initial begin
		wait (phase == 3);
		repeat (3) @(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	task automatic send_sample(input mos_pkg::sample_t s, input logic is_last);
		while ($urandom_range(99) < tx_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid  <= 1'b1;
		in_ch.sample <= s;
		in_ch.last   <= is_last;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	function automatic mos_pkg::sample_t pick_sample(input int mode);
		int v;
		case (mode)
			0: v = int'($urandom);
			1: v = int'($urandom_range(8)) - 4;
			2: begin
				case ($urandom_range(3))
					0: v = 32'h7FFF_FFFF;
					1: v = 32'h8000_0000;
					2: v = 0;
					default: v = -1;
				endcase
			end
			default: v = int'($urandom_range(65535)) - 32768;
		endcase
		return mos_pkg::sample_t'(v);
	endfunction

	task automatic send_set(input int n, input int mode);
		for (int i = 0; i < n; i++)
			send_sample(pick_sample(mode), i == n - 1);
		sets_sent++;
		samples_stored += (n > mos_pkg::CAPACITY) ? mos_pkg::CAPACITY : n;
		if (n >= mos_pkg::CAPACITY)
			full_sets++;
	endtask

	task automatic send_fixed(input mos_pkg::sample_t a, input mos_pkg::sample_t b,
		input mos_pkg::sample_t c, input int n);
		if (n >= 1) send_sample(a, n == 1);
		if (n >= 2) send_sample(b, n == 2);
		if (n >= 3) send_sample(c, n == 3);
		sets_sent++;
		samples_stored += n;
	endtask

	task automatic random_sets(input int first_size, input int budget);
		int stored;
		int n;
		int r;
		stored = 0;
		// each phase opens with a set at or past capacity
		send_set(first_size, $urandom_range(3));
		stored += (first_size > mos_pkg::CAPACITY) ? mos_pkg::CAPACITY : first_size;
		while (stored < budget) begin
			r = $urandom_range(99);
			if (r < 70)
				n = $urandom_range(10, 1);
			else if (r < 85)
				n = $urandom_range(40, 11);
			else if (r < 95)
				n = $urandom_range(mos_pkg::CAPACITY + 2, mos_pkg::CAPACITY - 2);
			else
				n = $urandom_range(mos_pkg::CAPACITY + 16, mos_pkg::CAPACITY + 3);
			send_set(n, $urandom_range(3));
			stored += (n > mos_pkg::CAPACITY) ? mos_pkg::CAPACITY : n;
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		done         = 1'b0;
		in_ch.valid  = 1'b0;
		in_ch.sample = '0;
		in_ch.last   = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		phase   = 1;
		tx_idle = 20;
		rx_idle = 84;
		// single-sample sets at both extremes
		send_fixed(32'h7FFF_FFFF, '0, '0, 1);
		send_fixed(32'h8000_0000, '0, '0, 1);
		// even sets: largest and smallest sums, mixed signs
		send_fixed(32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, 2);
		send_fixed(32'h8000_0000, 32'h8000_0000, '0, 2);
		send_fixed(32'h8000_0000, 32'h7FFF_FFFF, '0, 2);
		// equal samples
		send_fixed(32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 3);
		// descending order moves every held value up on each insert
		send_sample(32'h0003_0000, 1'b0);
		send_sample(32'h0002_0000, 1'b0);
		send_sample(32'h0001_0000, 1'b0);
		send_sample(32'hFFFF_0000, 1'b1);
		sets_sent++;
		samples_stored += 4;
		send_fixed(32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000, 3);
		// last sample lands on a full chain and is dropped
		random_sets(mos_pkg::CAPACITY + 1, PHASE_BUDGET);

		phase   = 2;
		tx_idle = 84;
		rx_idle = 20;
		random_sets(mos_pkg::CAPACITY, PHASE_BUDGET);

		phase   = 3;
		tx_idle = 0;
		rx_idle = 0;
		random_sets(mos_pkg::CAPACITY + 6, PHASE_BUDGET);
		in_ch.valid <= 1'b0;

		@(posedge clk);
		wait (outstanding == 0);
		repeat (40) @(posedge clk);
		done <= 1'b1;
		repeat (2) @(posedge clk);

		$display("Covered %0d sets (%0d stored samples, %0d at or past capacity),",
			sets_sent, samples_stored, full_sets);
		$display("%0d medians checked under three idle mixes and one %0d-cycle output stall.",
			medians_checked, HOLD_CYCLES);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/mos_pkg.sv
hdl/mos_in_if.sv
hdl/mos_out_if.sv
hdl/mos_cell.sv
hdl/mos_chain.sv
hdl/median_of_set_core.sv
tb/median_of_set_checker.sv
tb/median_of_set_core_tb.sv
